// ===== rtl/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared codes and controller/datapath interface types for the Go-Back-N
// window controller.
// ----------------------------------------------------------------------------
package gbn_pkg;

    typedef enum logic [1:0] {
        ACT_NEW_PACKET = 2'd0,
        ACT_LINK_READY = 2'd1,
        ACT_FRAME_RX   = 2'd2,
        ACT_TIMEOUT    = 2'd3
    } t_action;

    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_SEND    = 2'd1;
    localparam logic [1:0] KIND_DELIVER = 2'd2;

    localparam logic [7:0] FRAME_KIND_DATA = 8'd1;
    localparam logic [9:0] MIN_FRAME_LEN   = 10'd5;
    localparam logic [9:0] FRAME_OVERHEAD  = 10'd7;

    // resend burst limit and its counter width
    localparam int MAX_BURST = 8;
    localparam int LEFT_W    = 4;

    typedef struct packed {
        logic capture;
        logic exec;
        logic tmo_init;
        logic tmo_step;
    } t_ctrl_cmd;

    typedef struct packed {
        t_action action;
        logic    buf_zero;
        logic    left_last;
    } t_ctrl_sts;

endpackage

// ===== rtl/gbn_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbn_ctrl
// Sequencer: accepts a transaction, runs single-result events in one step
// and walks the resend burst on a timeout with frames buffered.
// ----------------------------------------------------------------------------
module gbn_ctrl
    import gbn_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    output logic      o_busy,
    output t_ctrl_cmd o_cmd,
    input  t_ctrl_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SEND
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   burst;

    assign burst = (i_sts.action == ACT_TIMEOUT) && !i_sts.buf_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_DECODE;
                        r_busy  <= 1'b1;
                    end
                end
                S_DECODE: begin
                    if (burst) begin
                        r_state <= S_SEND;
                    end else begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                S_SEND: begin
                    if (i_sts.left_last) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.capture  = (r_state == S_IDLE) && i_start;
        o_cmd.exec     = (r_state == S_DECODE) && !burst;
        o_cmd.tmo_init = (r_state == S_DECODE) && burst;
        o_cmd.tmo_step = (r_state == S_SEND);
    end

    assign o_busy = r_busy;

endmodule

// ===== rtl/gbn_datapath.sv =====
// ----------------------------------------------------------------------------
// gbn_datapath
// Window state, packet handle store, transaction capture and result register.
// ----------------------------------------------------------------------------
module gbn_datapath
    import gbn_pkg::*;
#(
    parameter int MAX_SEQUENCE = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl_cmd   i_cmd,
    output t_ctrl_sts   o_sts,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_new_packet_handle,
    input  logic        i_frame_good,
    input  logic [7:0]  i_frame_kind,
    input  logic [2:0]  i_frame_seq,
    input  logic [2:0]  i_frame_ack,
    input  logic [15:0] i_frame_payload_handle,
    input  logic [9:0]  i_frame_length,
    output logic        o_result_valid,
    output logic [1:0]  o_result_kind,
    output logic [2:0]  o_send_seq,
    output logic [2:0]  o_send_ack,
    output logic [15:0] o_out_packet_handle,
    output logic [9:0]  o_out_length,
    output logic [7:0]  o_stop_timer_mask,
    output logic        o_network_enable,
    output logic        o_last_result
);

    localparam int SEQ_MOD = MAX_SEQUENCE + 1;
    localparam int SEQ_W   = $clog2(SEQ_MOD);
    localparam int AW      = (SEQ_W > 3) ? SEQ_W : 3;
    localparam int BW      = (SEQ_W > LEFT_W) ? SEQ_W : LEFT_W;

    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] x);
        return (x == SEQ_W'(MAX_SEQUENCE)) ? '0 : x + SEQ_W'(1);
    endfunction

    function automatic logic [SEQ_W-1:0] seq_dist(input logic [SEQ_W-1:0] a,
                                                   input logic [SEQ_W-1:0] b);
        logic [SEQ_W:0] t;
        if (a >= b) begin
            t = {1'b0, a} - {1'b0, b};
        end else begin
            t = {1'b0, a} + (SEQ_W+1)'(SEQ_MOD) - {1'b0, b};
        end
        return t[SEQ_W-1:0];
    endfunction

    function automatic logic [SEQ_W-1:0] seq_add(input logic [SEQ_W-1:0] a,
                                                  input logic [SEQ_W-1:0] b);
        logic [SEQ_W:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t >= (SEQ_W+1)'(SEQ_MOD)) begin
            t = t - (SEQ_W+1)'(SEQ_MOD);
        end
        return t[SEQ_W-1:0];
    endfunction

    function automatic logic [2:0] to_seq3(input logic [SEQ_W-1:0] x);
        logic [AW-1:0] t;
        t = AW'(x);
        return t[2:0];
    endfunction

    // captured transaction
    t_action     r_action;
    logic [15:0] r_handle;
    logic        r_good;
    logic [7:0]  r_fkind;
    logic [2:0]  r_fseq;
    logic [2:0]  r_fack;
    logic [15:0] r_phandle;
    logic [9:0]  r_flen;

    // window state
    logic [SEQ_W-1:0] r_oldest;
    logic [SEQ_W-1:0] r_next;
    logic [SEQ_W-1:0] r_expected;
    logic [SEQ_W-1:0] r_buf;
    logic             r_link;

    logic [15:0]       mem [SEQ_MOD];
    logic [15:0]       r_rd_data;
    logic [SEQ_W-1:0]  r_seq;
    logic [LEFT_W-1:0] r_left;

    logic              r_valid;
    logic [1:0]        r_kind;
    logic [2:0]        r_sseq;
    logic [2:0]        r_sack;
    logic [15:0]       r_ohandle;
    logic [9:0]        r_olen;
    logic [7:0]        r_mask;
    logic              r_ne;
    logic              r_last;

    logic [1:0]        n_kind;
    logic [2:0]        n_sseq;
    logic [2:0]        n_sack;
    logic [15:0]       n_ohandle;
    logic [9:0]        n_olen;
    logic [7:0]        n_mask;
    logic              n_ne;
    logic              n_last;

    logic              win_full;
    logic              frame_ok;
    logic              deliver;
    logic              ack_hit;
    logic              left_last;
    logic [AW-1:0]     fack_ext;
    logic [SEQ_W-1:0]  fack_c;
    logic [SEQ_W-1:0]  d_ack;
    logic [SEQ_W-1:0]  d_win;
    logic [SEQ_W:0]    freed;
    logic [SEQ_W-1:0]  buf_after;
    logic [SEQ_W-1:0]  ack_out;
    logic [SEQ_W-1:0]  rd_addr;
    logic [BW-1:0]     buf_ext;
    logic [LEFT_W-1:0] burst_len;
    logic [9:0]        len_out;
    logic [7:0]        ack_mask;
    logic              new_send;

    assign win_full  = r_buf >= SEQ_W'(MAX_SEQUENCE);
    assign frame_ok  = r_good && (r_flen >= MIN_FRAME_LEN) && (r_fkind == FRAME_KIND_DATA);
    assign deliver   = frame_ok && (AW'(r_fseq) == AW'(r_expected));
    assign left_last = (r_left == LEFT_W'(1));
    assign new_send  = i_cmd.exec && (r_action == ACT_NEW_PACKET) && !win_full;

    // an ack beyond the sequence space behaves as the top sequence number
    assign fack_ext  = AW'(r_fack);
    assign fack_c    = (fack_ext > AW'(MAX_SEQUENCE)) ? SEQ_W'(MAX_SEQUENCE)
                                                      : fack_ext[SEQ_W-1:0];
    assign d_ack     = seq_dist(fack_c, r_oldest);
    assign d_win     = seq_dist(r_next, r_oldest);
    assign ack_hit   = frame_ok && (d_ack < d_win);
    assign freed     = {1'b0, d_ack} + (SEQ_W+1)'(1);
    assign buf_after = (freed >= {1'b0, r_buf}) ? '0 : r_buf - freed[SEQ_W-1:0];

    assign ack_out   = (r_expected == '0) ? SEQ_W'(MAX_SEQUENCE) : r_expected - SEQ_W'(1);
    assign len_out   = (r_flen >= FRAME_OVERHEAD) ? r_flen - FRAME_OVERHEAD : '0;
    assign rd_addr   = i_cmd.tmo_init ? r_oldest : seq_inc(r_seq);
    assign buf_ext   = BW'(r_buf);
    assign burst_len = (buf_ext > BW'(MAX_BURST)) ? LEFT_W'(MAX_BURST)
                                                  : buf_ext[LEFT_W-1:0];

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            ack_mask[j] = ack_hit && (j < SEQ_MOD) &&
                          (seq_dist(SEQ_W'(j), r_oldest) <= d_ack);
        end
    end

    always_comb begin
        n_kind    = KIND_STATUS;
        n_sseq    = '0;
        n_sack    = '0;
        n_ohandle = '0;
        n_olen    = '0;
        n_mask    = '0;
        n_ne      = 1'b0;
        n_last    = 1'b1;
        if (i_cmd.tmo_step) begin
            n_kind    = KIND_SEND;
            n_sseq    = to_seq3(r_seq);
            n_sack    = to_seq3(ack_out);
            n_ohandle = r_rd_data;
            n_last    = left_last;
        end else begin
            unique case (r_action)
                ACT_NEW_PACKET: begin
                    if (!win_full) begin
                        n_kind    = KIND_SEND;
                        n_sseq    = to_seq3(r_next);
                        n_sack    = to_seq3(ack_out);
                        n_ohandle = r_handle;
                    end
                end
                ACT_LINK_READY: begin
                    n_ne = !win_full;
                end
                ACT_FRAME_RX: begin
                    n_mask = ack_mask;
                    n_ne   = r_link && (ack_hit || !win_full);
                    if (deliver) begin
                        n_kind    = KIND_DELIVER;
                        n_ohandle = r_phandle;
                        n_olen    = len_out;
                    end
                end
                ACT_TIMEOUT: begin
                    n_ne = r_link;
                end
                default: begin
                    n_ne = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest   <= '0;
            r_next     <= '0;
            r_expected <= '0;
            r_buf      <= '0;
            r_link     <= 1'b0;
            r_seq      <= '0;
            r_left     <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= i_cmd.exec || i_cmd.tmo_step;
            if (i_cmd.exec) begin
                unique case (r_action)
                    ACT_NEW_PACKET: begin
                        if (!win_full) begin
                            r_buf  <= r_buf + SEQ_W'(1);
                            r_next <= seq_inc(r_next);
                            r_link <= 1'b0;
                        end
                    end
                    ACT_LINK_READY: begin
                        r_link <= 1'b1;
                    end
                    ACT_FRAME_RX: begin
                        if (deliver) begin
                            r_expected <= seq_inc(r_expected);
                        end
                        if (ack_hit) begin
                            r_oldest <= seq_inc(fack_c);
                            r_buf    <= buf_after;
                        end
                    end
                    ACT_TIMEOUT: begin
                        r_link <= r_link;
                    end
                    default: begin
                        r_link <= r_link;
                    end
                endcase
            end
            if (i_cmd.tmo_init) begin
                r_seq  <= r_oldest;
                r_left <= burst_len;
            end
            if (i_cmd.tmo_step) begin
                r_seq  <= seq_inc(r_seq);
                r_left <= r_left - LEFT_W'(1);
                if (left_last) begin
                    r_link <= 1'b0;
                    r_next <= seq_add(r_oldest, r_buf);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action  <= t_action'(i_action);
            r_handle  <= i_new_packet_handle;
            r_good    <= i_frame_good;
            r_fkind   <= i_frame_kind;
            r_fseq    <= i_frame_seq;
            r_fack    <= i_frame_ack;
            r_phandle <= i_frame_payload_handle;
            r_flen    <= i_frame_length;
        end
        if (new_send) begin
            mem[r_next] <= r_handle;
        end
        if (i_cmd.tmo_init || i_cmd.tmo_step) begin
            r_rd_data <= mem[rd_addr];
        end
        if (i_cmd.exec || i_cmd.tmo_step) begin
            r_kind    <= n_kind;
            r_sseq    <= n_sseq;
            r_sack    <= n_sack;
            r_ohandle <= n_ohandle;
            r_olen    <= n_olen;
            r_mask    <= n_mask;
            r_ne      <= n_ne;
            r_last    <= n_last;
        end
    end

    always_comb begin
        o_sts.action    = r_action;
        o_sts.buf_zero  = (r_buf == '0);
        o_sts.left_last = left_last;
    end

    assign o_result_valid      = r_valid;
    assign o_result_kind       = r_kind;
    assign o_send_seq          = r_sseq;
    assign o_send_ack          = r_sack;
    assign o_out_packet_handle = r_ohandle;
    assign o_out_length        = r_olen;
    assign o_stop_timer_mask   = r_mask;
    assign o_network_enable    = r_ne;
    assign o_last_result       = r_last;

endmodule

// ===== rtl/go_back_n_window_control.sv =====
// ----------------------------------------------------------------------------
// go_back_n_window_control
// The result is registered from the decode state that follows acceptance; on a timeout with
// frames buffered, decode instead loads the first stored handle and the send state then
// resends n = min(buffered, 8) frames, one resent frame per cycle, paced by the single read
// port of the handle store. A new transaction is accepted only once busy falls.
// Results are strobed for one cycle each; the receiver cannot stall.
// Reset clears window state and the link flag; the handle store is not cleared.
// ----------------------------------------------------------------------------
module go_back_n_window_control
    import gbn_pkg::*;
#(
    parameter int MAX_SEQUENCE = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_new_packet_handle,
    input  logic        i_frame_good,
    input  logic [7:0]  i_frame_kind,
    input  logic [2:0]  i_frame_seq,
    input  logic [2:0]  i_frame_ack,
    input  logic [15:0] i_frame_payload_handle,
    input  logic [9:0]  i_frame_length,
    output logic        o_result_valid,
    output logic [1:0]  o_result_kind,
    output logic [2:0]  o_send_seq,
    output logic [2:0]  o_send_ack,
    output logic [15:0] o_out_packet_handle,
    output logic [9:0]  o_out_length,
    output logic [7:0]  o_stop_timer_mask,
    output logic        o_network_enable,
    output logic        o_last_result
);

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    gbn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    gbn_datapath #(
        .MAX_SEQUENCE (MAX_SEQUENCE)
    ) u_datapath (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .o_sts                  (sts),
        .i_action               (i_action),
        .i_new_packet_handle    (i_new_packet_handle),
        .i_frame_good           (i_frame_good),
        .i_frame_kind           (i_frame_kind),
        .i_frame_seq            (i_frame_seq),
        .i_frame_ack            (i_frame_ack),
        .i_frame_payload_handle (i_frame_payload_handle),
        .i_frame_length         (i_frame_length),
        .o_result_valid         (o_result_valid),
        .o_result_kind          (o_result_kind),
        .o_send_seq             (o_send_seq),
        .o_send_ack             (o_send_ack),
        .o_out_packet_handle    (o_out_packet_handle),
        .o_out_length           (o_out_length),
        .o_stop_timer_mask      (o_stop_timer_mask),
        .o_network_enable       (o_network_enable),
        .o_last_result          (o_last_result)
    );

`ifndef SYNTHESIS
    // a resend burst is strobed on consecutive cycles
    a_burst_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_last_result |=> o_result_valid)
        else $error("resend burst has a gap");

    a_single_nonsend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_result_kind != KIND_SEND) |-> o_last_result)
        else $error("status or delivery result not marked last");

    a_busy_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_last_result |-> busy)
        else $error("idle while results are pending");

    a_send_clears_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_result_kind == KIND_SEND) |-> !o_network_enable)
        else $error("network enabled after a frame was sent");
`endif

endmodule
